// File: src/gzhp_pkg.sv
// Shared types and constants for the gzip member header parser.
package gzhp_pkg;

	// Longest file name that is passed on, in bytes.
	localparam int MAX_NAME_LEN = 255;
	localparam int NAME_CNT_W   = $clog2(MAX_NAME_LEN + 1);

	// Fixed header layout.
	localparam int         HDR_LEN      = 10;
	localparam logic [7:0] MAGIC0       = 8'h1F;
	localparam logic [7:0] MAGIC1       = 8'h8B;
	localparam int         FLG_EXTRA    = 2;
	localparam int         FLG_NAME     = 3;
	localparam logic [3:0] IDX_MAGIC0   = 4'd0;
	localparam logic [3:0] IDX_MAGIC1   = 4'd1;
	localparam logic [3:0] IDX_METHOD   = 4'd2;
	localparam logic [3:0] IDX_FLAGS    = 4'd3;
	localparam logic [3:0] IDX_XFL      = 4'd8;
	localparam logic [3:0] IDX_HDR_LAST = 4'(HDR_LEN - 1);

	// Result queue depth; a power of two.
	localparam int OUT_DEPTH = 4;

	// Result kinds.
	localparam logic KIND_NAME    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_data;
	} in_beat_t;

	typedef struct packed {
		logic        result_kind;
		logic [7:0]  name_char;
		logic [7:0]  method;
		logic [7:0]  flag_bits;
		logic [31:0] mod_time;
		logic [7:0]  extra_flag_byte;
		logic [7:0]  os_code;
		logic        header_valid;
		logic        too_short;
		logic        last_result;
	} result_t;

	// Results of one input beat, handed to the result queue.
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// File: src/gzhp_byte_if.sv
// Channel carrying stream bytes into the parser.
interface gzhp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_data;

	modport source(output valid, output in_byte, output end_of_data, input ready);
	modport sink(input valid, input in_byte, input end_of_data, output ready);
endinterface

// File: src/gzhp_result_if.sv
// Channel carrying name bytes and header summaries out of the parser.
interface gzhp_result_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  name_char;
	logic [7:0]  method;
	logic [7:0]  flag_bits;
	logic [31:0] mod_time;
	logic [7:0]  extra_flag_byte;
	logic [7:0]  os_code;
	logic        header_valid;
	logic        too_short;
	logic        last_result;

	modport source(output valid, output result_kind, output name_char, output method,
		output flag_bits, output mod_time, output extra_flag_byte, output os_code,
		output header_valid, output too_short, output last_result, input ready);
	modport sink(input valid, input result_kind, input name_char, input method,
		input flag_bits, input mod_time, input extra_flag_byte, input os_code,
		input header_valid, input too_short, input last_result, output ready);
endinterface

// File: src/gzhp_parse_core.sv
// Header parse state and per-byte result generation.
module gzhp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  gzhp_pkg::in_beat_t beat,
	output gzhp_pkg::push_t    push
);

	typedef enum logic [4:0] {
		PH_HEADER = 5'b00001,
		PH_XLEN   = 5'b00010,
		PH_SKIP   = 5'b00100,
		PH_NAME   = 5'b01000,
		PH_DONE   = 5'b10000
	} phase_t;

	localparam int NCW = gzhp_pkg::NAME_CNT_W;

	phase_t          phase_q, phase_st;
	logic [3:0]      byte_index_q, byte_index_st;
	logic            magic_ok_q, magic_ok_st;
	logic [7:0]      method_q, method_st;
	logic [7:0]      flags_q, flags_st;
	logic [31:0]     time_q, time_st;
	logic [7:0]      xfl_q, xfl_st;
	logic [7:0]      os_q, os_st;
	logic [15:0]     skip_q, skip_st;
	logic [NCW-1:0]  name_count_q, name_count_st;
	logic [NCW-1:0]  name_count_inc;
	logic [15:0]     skip_dec;
	logic            emit;
	logic            shrt;
	logic            hdr_ok;
	logic [7:0]      b;
	gzhp_pkg::result_t name_res;
	gzhp_pkg::result_t sum_res;

	assign b              = beat.in_byte;
	assign name_count_inc = name_count_q + NCW'(1);
	assign skip_dec       = skip_q - 16'd1;

	// State step for one byte.
	always_comb begin
		phase_st      = phase_q;
		byte_index_st = byte_index_q;
		magic_ok_st   = magic_ok_q;
		method_st     = method_q;
		flags_st      = flags_q;
		time_st       = time_q;
		xfl_st        = xfl_q;
		os_st         = os_q;
		skip_st       = skip_q;
		name_count_st = name_count_q;
		emit          = 1'b0;
		unique case (phase_q)
			PH_HEADER: begin
				if (byte_index_q == gzhp_pkg::IDX_MAGIC0 && b != gzhp_pkg::MAGIC0) begin
					magic_ok_st = 1'b0;
				end
				if (byte_index_q == gzhp_pkg::IDX_MAGIC1 && b != gzhp_pkg::MAGIC1) begin
					magic_ok_st = 1'b0;
				end
				if (byte_index_q == gzhp_pkg::IDX_METHOD) begin
					method_st = b;
				end
				if (byte_index_q == gzhp_pkg::IDX_FLAGS) begin
					flags_st = b;
				end
				// Offsets four to seven fill the time word, low byte first.
				if (byte_index_q[3:2] == 2'b01) begin
					time_st[{byte_index_q[1:0], 3'b000} +: 8] = b;
				end
				if (byte_index_q == gzhp_pkg::IDX_XFL) begin
					xfl_st = b;
				end
				if (byte_index_q >= gzhp_pkg::IDX_HDR_LAST) begin
					os_st         = b;
					byte_index_st = 4'd0;
					if (magic_ok_q && flags_q[gzhp_pkg::FLG_NAME]) begin
						if (flags_q[gzhp_pkg::FLG_EXTRA]) begin
							phase_st = PH_XLEN;
							skip_st  = 16'd0;
						end else begin
							phase_st      = PH_NAME;
							name_count_st = '0;
						end
					end else begin
						phase_st = PH_DONE;
					end
				end else begin
					byte_index_st = byte_index_q + 4'd1;
				end
			end
			PH_XLEN: begin
				if (byte_index_q == 4'd0) begin
					skip_st       = {8'd0, b};
					byte_index_st = 4'd1;
				end else begin
					skip_st       = {b, skip_q[7:0]};
					byte_index_st = 4'd0;
					if ({b, skip_q[7:0]} == 16'd0) begin
						phase_st      = PH_NAME;
						name_count_st = '0;
					end else begin
						phase_st = PH_SKIP;
					end
				end
			end
			PH_SKIP: begin
				skip_st = skip_dec;
				if (skip_dec == 16'd0) begin
					phase_st      = PH_NAME;
					name_count_st = '0;
				end
			end
			PH_NAME: begin
				if (b == 8'd0) begin
					phase_st = PH_DONE;
				end else begin
					emit          = 1'b1;
					name_count_st = name_count_inc;
					if (name_count_inc >= NCW'(gzhp_pkg::MAX_NAME_LEN)) begin
						phase_st = PH_DONE;
					end
				end
			end
			PH_DONE: begin
				phase_st = PH_DONE;
			end
			default: begin
				phase_st = PH_DONE;
			end
		endcase
	end

	// Build the name byte and summary results from the stepped state.
	always_comb begin
		shrt   = (phase_st == PH_HEADER);
		hdr_ok = !shrt && magic_ok_st;

		name_res             = '0;
		name_res.result_kind = gzhp_pkg::KIND_NAME;
		name_res.name_char   = b;

		sum_res              = '0;
		sum_res.result_kind  = gzhp_pkg::KIND_SUMMARY;
		if (hdr_ok) begin
			sum_res.method          = method_st;
			sum_res.flag_bits       = flags_st;
			sum_res.mod_time        = time_st;
			sum_res.extra_flag_byte = xfl_st;
			sum_res.os_code         = os_st;
		end
		sum_res.header_valid = hdr_ok;
		sum_res.too_short    = shrt;
		sum_res.last_result  = 1'b1;

		push.first  = emit ? name_res : sum_res;
		push.second = sum_res;
		if (!fire) begin
			push.count = 2'd0;
		end else begin
			push.count = {1'b0, emit} + {1'b0, beat.end_of_data};
		end
	end

	// Control state; the final byte of a stream returns it to reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_HEADER;
			byte_index_q <= 4'd0;
			magic_ok_q   <= 1'b1;
		end else if (fire) begin
			if (beat.end_of_data) begin
				phase_q      <= PH_HEADER;
				byte_index_q <= 4'd0;
				magic_ok_q   <= 1'b1;
			end else begin
				phase_q      <= phase_st;
				byte_index_q <= byte_index_st;
				magic_ok_q   <= magic_ok_st;
			end
		end
	end

	// Captured header fields and counters; each is written before it is read.
	always_ff @(posedge clk) begin
		if (fire) begin
			method_q     <= method_st;
			flags_q      <= flags_st;
			time_q       <= time_st;
			xfl_q        <= xfl_st;
			os_q         <= os_st;
			skip_q       <= skip_st;
			name_count_q <= name_count_st;
		end
	end

	// A stream end always leaves the parser ready for a fresh header.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat.end_of_data |=> phase_q == PH_HEADER && byte_index_q == 4'd0 && magic_ok_q)
	else $error("parser not back at header start after final byte");

	// The name counter stays under its limit while names are passed on.
	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_NAME |-> name_count_q < NCW'(gzhp_pkg::MAX_NAME_LEN))
	else $error("name counter reached its limit inside the name phase");

	// A name byte result is only produced in the name phase.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && emit |-> phase_q == PH_NAME && b != 8'd0)
	else $error("name byte produced outside the name phase");

endmodule

// File: src/gzhp_out_fifo.sv
// Small result queue that takes up to two results per cycle and gives one per cycle while the receiver is ready.
module gzhp_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  gzhp_pkg::push_t   push,
	output logic              room,
	output logic              head_valid,
	output gzhp_pkg::result_t head,
	input  logic              pop_ready
);

	localparam int DEPTH = gzhp_pkg::OUT_DEPTH;
	localparam int PW    = $clog2(DEPTH);
	localparam int CW    = $clog2(DEPTH + 1);

	gzhp_pkg::result_t mem_q [DEPTH];
	logic [PW-1:0]     wr_ptr_q;
	logic [PW-1:0]     rd_ptr_q;
	logic [CW-1:0]     count_q;
	logic              pop;

	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign pop        = head_valid && pop_ready;
	// Room for the two results that one byte can cause.
	assign room       = (count_q <= CW'(DEPTH - 2));

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_ptr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_ptr_q + PW'(1)] <= push.second;
		end
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PW'(push.count);
			rd_ptr_q <= rd_ptr_q + PW'(pop);
			count_q  <= count_q + CW'(push.count) - CW'(pop);
		end
	end

	// The fill level never passes the depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CW'(DEPTH))
	else $error("result queue overflow");

	// Results arrive only when there is room for a full pair.
	assert property (@(posedge clk) disable iff (!arst_n)
		push.count != 2'd0 |-> count_q <= CW'(DEPTH - 2))
	else $error("results pushed without room");

	// An entry that is waiting and not taken stays at the head.
	assert property (@(posedge clk) disable iff (!arst_n)
		head_valid && !pop_ready |=> head_valid && $stable(rd_ptr_q))
	else $error("result queue head moved while stalled");

endmodule

// File: src/gzip_header_parser.sv
// Top level of the gzip member header parser.
// A byte accepted from the input is registered in the input stage, parsed from there into the
// result queue, and its first result is offered from the queue head.
// Throughput: one byte per cycle; the input is held only while the result queue has fewer
// than two free entries. A final byte that is also a name byte gives two results.
// Reset: arst_n clears the parse control state, the input stage valid and the result queue.
module gzip_header_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	gzhp_byte_if.sink            byte_stream,
	gzhp_result_if.source        result_stream
);

	logic               valid_s1;
	gzhp_pkg::in_beat_t beat_s1;
	logic               advance;
	logic               room;
	logic               head_valid;
	gzhp_pkg::push_t    push;
	gzhp_pkg::result_t  head;

	// The input stage moves on whenever the queue can take a pair of results.
	assign advance           = valid_s1 && room;
	assign byte_stream.ready = !valid_s1 || advance;

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_stream.ready) begin
			valid_s1 <= byte_stream.valid;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (byte_stream.ready && byte_stream.valid) begin
			beat_s1.in_byte     <= byte_stream.in_byte;
			beat_s1.end_of_data <= byte_stream.end_of_data;
		end
	end

	gzhp_parse_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.beat   (beat_s1),
		.push   (push)
	);

	gzhp_out_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.room       (room),
		.head_valid (head_valid),
		.head       (head),
		.pop_ready  (result_stream.ready)
	);

	// Drive the result channel from the queue head.
	assign result_stream.valid           = head_valid;
	assign result_stream.result_kind     = head.result_kind;
	assign result_stream.name_char       = head.name_char;
	assign result_stream.method          = head.method;
	assign result_stream.flag_bits       = head.flag_bits;
	assign result_stream.mod_time        = head.mod_time;
	assign result_stream.extra_flag_byte = head.extra_flag_byte;
	assign result_stream.os_code         = head.os_code;
	assign result_stream.header_valid    = head.header_valid;
	assign result_stream.too_short       = head.too_short;
	assign result_stream.last_result     = head.last_result;

endmodule

// File: dv/gzip_header_parser_tb.sv
// Testbench for the gzip header parser: random and directed streams checked against a predictor.
module gzip_header_parser_tb;
	import gzhp_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_XLEN,
		PH_SKIP,
		PH_NAME,
		PH_DONE
	} parse_phase_t;

	localparam int         CYCLE_LIMIT     = 500000;
	localparam int         RANDOM_BYTES    = 950;
	localparam int         MAX_WAIT        = 11;
	localparam int         HOLD_CYCLES     = 300;
	localparam int         SETTLE_CYCLES   = 4;
	localparam int         MAX_SKIP_SENT   = 40;
	localparam logic [3:0] IDX_TIME_LO     = 4'd4;
	localparam logic [3:0] IDX_TIME_HI     = 4'd7;
	localparam logic [7:0] METHOD_DEFLATE  = 8'h08;
	localparam logic [7:0] FLAGS_NAME_ONLY = 8'(1 << FLG_NAME);
	localparam logic [7:0] NAME_END        = 8'h00;

	logic clk = 1'b0;
	logic arst_n;

	gzhp_byte_if   byte_ch();
	gzhp_result_if result_ch();

	gzip_header_parser i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_stream(byte_ch),
		.result_stream(result_ch)
	);

	// Parse state of the predictor.
	parse_phase_t ph;
	logic [3:0]   hdr_idx;
	logic         magic_seen_ok;
	logic [7:0]   method_q;
	logic [7:0]   flags_q;
	logic [31:0]  mtime_q;
	logic [7:0]   xfl_q;
	logic [7:0]   os_q;
	logic [15:0]  skip_left;
	int           name_len_seen;

	result_t    header_results_q[$];
	logic [7:0] stream_bytes[$];

	bit sender_idles    = 1'b0;
	bit receiver_stalls = 1'b0;
	bit long_hold       = 1'b0;
	int mismatch_count  = 0;
	int bytes_sent      = 0;
	int cycle_count     = 0;

	// Clock with a period of four time units.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Generous limit on the length of the run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no progress within the cycle limit", $time);
			$display("FAIL");
			$finish;
		end
	end

	function automatic void clear_parse_state();
		ph            = PH_HEADER;
		hdr_idx       = '0;
		magic_seen_ok = 1'b1;
		method_q      = '0;
		flags_q       = '0;
		mtime_q       = '0;
		xfl_q         = '0;
		os_q          = '0;
		skip_left     = '0;
		name_len_seen = 0;
	endfunction

	function automatic void start_name();
		ph            = PH_NAME;
		name_len_seen = 0;
	endfunction

	// Advances the parse by one byte and queues the name byte and summary it produces.
	function automatic void parse_stream_byte(logic [7:0] b, logic eod);
		result_t r;
		case (ph)
			PH_HEADER: begin
				if (hdr_idx == IDX_MAGIC0 && b != MAGIC0) magic_seen_ok = 1'b0;
				if (hdr_idx == IDX_MAGIC1 && b != MAGIC1) magic_seen_ok = 1'b0;
				if (hdr_idx == IDX_METHOD) method_q = b;
				if (hdr_idx == IDX_FLAGS) flags_q = b;
				if (hdr_idx >= IDX_TIME_LO && hdr_idx <= IDX_TIME_HI)
					mtime_q[8 * (hdr_idx - IDX_TIME_LO) +: 8] = b;
				if (hdr_idx == IDX_XFL) xfl_q = b;
				if (hdr_idx == IDX_HDR_LAST) begin
					os_q    = b;
					hdr_idx = '0;
					if (magic_seen_ok && flags_q[FLG_NAME]) begin
						if (flags_q[FLG_EXTRA]) begin
							ph        = PH_XLEN;
							skip_left = '0;
						end else begin
							start_name();
						end
					end else begin
						ph = PH_DONE;
					end
				end else begin
					hdr_idx++;
				end
			end
			PH_XLEN: begin
				// Extra field length, low byte first.
				if (hdr_idx == '0) begin
					skip_left = {8'h00, b};
					hdr_idx   = 4'd1;
				end else begin
					skip_left[15:8] = b;
					hdr_idx         = '0;
					if (skip_left == '0) start_name();
					else ph = PH_SKIP;
				end
			end
			PH_SKIP: begin
				skip_left--;
				if (skip_left == '0) start_name();
			end
			PH_NAME: begin
				if (b == NAME_END) begin
					ph = PH_DONE;
				end else begin
					r             = '0;
					r.result_kind = KIND_NAME;
					r.name_char   = b;
					header_results_q.push_back(r);
					name_len_seen++;
					if (name_len_seen >= MAX_NAME_LEN) ph = PH_DONE;
				end
			end
			default: ph = PH_DONE;
		endcase

		// The final byte always closes the stream with a summary.
		if (eod) begin
			r              = '0;
			r.result_kind  = KIND_SUMMARY;
			r.too_short    = (ph == PH_HEADER);
			r.header_valid = !r.too_short && magic_seen_ok;
			if (r.header_valid) begin
				r.method          = method_q;
				r.flag_bits       = flags_q;
				r.mod_time        = mtime_q;
				r.extra_flag_byte = xfl_q;
				r.os_code         = os_q;
			end
			r.last_result = 1'b1;
			header_results_q.push_back(r);
			clear_parse_state();
		end
	endfunction

	// Offers one byte, after a random gap if the sender idles, and waits until the parser takes it.
	task automatic send_byte(logic [7:0] b, logic eod);
		int gap;
		gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
		@(negedge clk);
		if (gap > 0) begin
			byte_ch.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		byte_ch.valid       = 1'b1;
		byte_ch.in_byte     = b;
		byte_ch.end_of_data = eod;
		do @(posedge clk); while (!byte_ch.ready);
		parse_stream_byte(b, eod);
		bytes_sent++;
	endtask

	task automatic send_stream();
		foreach (stream_bytes[i])
			send_byte(stream_bytes[i], i == stream_bytes.size() - 1);
	endtask

	// Stops offering bytes and waits until every predicted result has been seen.
	task automatic drain_results();
		@(negedge clk);
		byte_ch.valid = 1'b0;
		while (header_results_q.size() != 0) @(posedge clk);
	endtask

	// Builds one stream: mostly well-formed members with random content, some broken.
	task automatic make_stream();
		int          shape;
		int          name_len;
		int          cut;
		logic [7:0]  flg;
		logic [15:0] xlen;
		stream_bytes.delete();
		shape = $urandom_range(0, 19);
		if (shape == 0) begin
			repeat ($urandom_range(1, 15)) stream_bytes.push_back(8'($urandom));
			return;
		end
		stream_bytes.push_back(shape == 1 ? 8'($urandom) : MAGIC0);
		stream_bytes.push_back(shape == 2 ? 8'($urandom) : MAGIC1);
		stream_bytes.push_back($urandom_range(0, 3) != 0 ? METHOD_DEFLATE : 8'($urandom));
		flg = 8'($urandom);
		if ($urandom_range(0, 5) != 0) flg[FLG_NAME] = 1'b1;
		stream_bytes.push_back(flg);
		repeat (6) stream_bytes.push_back(8'($urandom));

		if (flg[FLG_EXTRA]) begin
			xlen = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
			stream_bytes.push_back(xlen[7:0]);
			stream_bytes.push_back(xlen[15:8]);
			// A long extra field is always cut off before its end.
			if (xlen > MAX_SKIP_SENT) begin
				repeat ($urandom_range(0, 20)) stream_bytes.push_back(8'($urandom));
				return;
			end
			repeat (xlen) stream_bytes.push_back(8'($urandom));
		end

		// Names are short, except now and then one around the length limit.
		name_len = ($urandom_range(0, 39) == 0) ?
			$urandom_range(MAX_NAME_LEN - 5, MAX_NAME_LEN + 7) : $urandom_range(0, 12);
		repeat (name_len) stream_bytes.push_back(8'($urandom_range(1, 255)));
		if ($urandom_range(0, 3) != 0) begin
			stream_bytes.push_back(NAME_END);
			repeat ($urandom_range(0, 4)) stream_bytes.push_back(8'($urandom));
		end

		// Cut the stream at a random point now and then, also inside the header.
		if ($urandom_range(0, 7) == 0) begin
			cut = $urandom_range(1, stream_bytes.size());
			while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
		end
	endtask

	task automatic test_directed();
		sender_idles    = 1'b1;
		receiver_stalls = 1'b1;
		// A single byte of all ones: too short.
		stream_bytes = '{8'hFF};
		send_stream();
		// The stream ends right after the magic: too short.
		stream_bytes = '{MAGIC0, MAGIC1};
		send_stream();
		// Full header with a bad second magic byte: invalid, and the name flag is ignored.
		stream_bytes = '{MAGIC0, 8'h00, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF,
			8'h01, 8'hFE};
		send_stream();
		// The final byte is also the only name byte, so one beat gives two results.
		stream_bytes = '{MAGIC0, MAGIC1, METHOD_DEFLATE, FLAGS_NAME_ONLY, 8'h78, 8'h56,
			8'h34, 8'h12, 8'h00, 8'h03, 8'h41};
		send_stream();
		drain_results();
	endtask

	// A name past the limit while the receiver holds off, so the parser stalls its input.
	task automatic test_backpressure();
		sender_idles    = 1'b0;
		receiver_stalls = 1'b0;
		stream_bytes = '{MAGIC0, MAGIC1, METHOD_DEFLATE, FLAGS_NAME_ONLY};
		repeat (6) stream_bytes.push_back(8'($urandom));
		repeat (MAX_NAME_LEN + 15) stream_bytes.push_back(8'($urandom_range(1, 255)));
		long_hold = 1'b1;
		send_stream();
		drain_results();
	endtask

	task automatic test_random();
		int first;
		int mode;
		first = bytes_sent;
		while (bytes_sent - first < RANDOM_BYTES) begin
			// Each stream picks whether either side idles.
			mode            = $urandom_range(0, 3);
			sender_idles    = mode[0];
			receiver_stalls = mode[1];
			make_stream();
			send_stream();
		end
		drain_results();
	endtask

	// Result receiver: random stalls, and a long hold-off when one is requested.
	initial begin
		int stall;
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				result_ch.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				long_hold = 1'b0;
			end
			stall = receiver_stalls ? $urandom_range(0, MAX_WAIT) : 0;
			if (stall > 0) begin
				result_ch.ready = 1'b0;
				repeat (stall) @(negedge clk);
			end
			result_ch.ready = 1'b1;
			do @(posedge clk); while (!result_ch.valid);
		end
	end

	function automatic void compare_field(string field_name, logic [31:0] want,
		logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name,
				want, got);
			mismatch_count++;
		end
	endfunction

	// Each result beat is checked against the oldest predicted result.
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got.result_kind     = result_ch.result_kind;
			got.name_char       = result_ch.name_char;
			got.method          = result_ch.method;
			got.flag_bits       = result_ch.flag_bits;
			got.mod_time        = result_ch.mod_time;
			got.extra_flag_byte = result_ch.extra_flag_byte;
			got.os_code         = result_ch.os_code;
			got.header_valid    = result_ch.header_valid;
			got.too_short       = result_ch.too_short;
			got.last_result     = result_ch.last_result;
			if (header_results_q.size() == 0) begin
				$display("%0t: result with none expected, expected nothing, actual %0h",
					$time, got);
				mismatch_count++;
			end else begin
				want = header_results_q.pop_front();
				compare_field("result_kind", 32'(want.result_kind),
					32'(got.result_kind));
				compare_field("name_char", 32'(want.name_char), 32'(got.name_char));
				compare_field("method", 32'(want.method), 32'(got.method));
				compare_field("flag_bits", 32'(want.flag_bits), 32'(got.flag_bits));
				compare_field("mod_time", want.mod_time, got.mod_time);
				compare_field("extra_flag_byte", 32'(want.extra_flag_byte),
					32'(got.extra_flag_byte));
				compare_field("os_code", 32'(want.os_code), 32'(got.os_code));
				compare_field("header_valid", 32'(want.header_valid),
					32'(got.header_valid));
				compare_field("too_short", 32'(want.too_short), 32'(got.too_short));
				compare_field("last_result", 32'(want.last_result),
					32'(got.last_result));
			end
		end
	end

	// Reset, the tests in turn, then the verdict.
	initial begin
		arst_n              = 1'b0;
		byte_ch.valid       = 1'b0;
		byte_ch.in_byte     = '0;
		byte_ch.end_of_data = 1'b0;
		clear_parse_state();
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_backpressure();
		test_random();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule
